### hdl/ntv_pkg.sv
// shared types, codes and helpers for the newick token validator
`default_nettype none

package ntv_pkg;

   localparam int MAX_DEPTH_DEF  = 255;
   localparam int TOKEN_REF_BITS = 16;
   localparam int REF_W          = 16;
   localparam int NODE_DEPTH_W   = 8;

   localparam logic [REF_W-1:0] REF_MASK = (TOKEN_REF_BITS >= REF_W) ?
      {REF_W{1'b1}} : REF_W'((64'd1 << TOKEN_REF_BITS) - 64'd1);

   typedef enum logic [3:0] {
      KIND_NONE    = 4'd0,
      KIND_OPEN    = 4'd1,
      KIND_CLOSE   = 4'd2,
      KIND_SYMBOL  = 4'd3,
      KIND_STRING  = 4'd4,
      KIND_NUMBER  = 4'd5,
      KIND_TAG     = 4'd6,
      KIND_COMMENT = 4'd7,
      KIND_COMMA   = 4'd8,
      KIND_SEMI    = 4'd9,
      KIND_END     = 4'd10
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_LABEL   = 3'd1,
      ACT_VALUE   = 3'd2,
      ACT_TAG     = 3'd3,
      ACT_COMMENT = 3'd4,
      ACT_PUSH    = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_RUNNING       = 4'd0,
      ST_TREE_DONE     = 4'd1,
      ST_BAD_CHARS     = 4'd2,
      ST_REOPEN        = 4'd3,
      ST_NO_START      = 4'd4,
      ST_BAD_COMMA     = 4'd5,
      ST_EXTRA_CLOSE   = 4'd6,
      ST_BAD_CLOSE     = 4'd7,
      ST_MISSING_CLOSE = 4'd8,
      ST_BAD_SEMI      = 4'd9,
      ST_NO_SEMI       = 4'd10,
      ST_TOO_DEEP      = 4'd11
   } status_type;

   function automatic logic [15:0] kind_bit(kind_type k);
      logic [15:0] m;
      m = 16'd0;
      m[k] = 1'b1;
      return m;
   endfunction

   // allowed predecessors per token kind
   localparam logic [15:0] PRE_OPEN = kind_bit(KIND_OPEN) | kind_bit(KIND_COMMA)
                                    | kind_bit(KIND_COMMENT);
   localparam logic [15:0] PRE_NAME = kind_bit(KIND_OPEN) | kind_bit(KIND_CLOSE)
                                    | kind_bit(KIND_COMMA) | kind_bit(KIND_COMMENT);
   localparam logic [15:0] PRE_NUMBER = PRE_NAME | kind_bit(KIND_SYMBOL)
                                      | kind_bit(KIND_STRING);
   localparam logic [15:0] PRE_COMMA = PRE_NUMBER | kind_bit(KIND_NUMBER)
                                     | kind_bit(KIND_TAG);
   localparam logic [15:0] PRE_CLOSE = kind_bit(KIND_CLOSE) | kind_bit(KIND_TAG)
                                     | kind_bit(KIND_COMMENT) | kind_bit(KIND_SYMBOL)
                                     | kind_bit(KIND_STRING) | kind_bit(KIND_NUMBER)
                                     | kind_bit(KIND_COMMA);
   localparam logic [15:0] PRE_SEMI = kind_bit(KIND_CLOSE) | kind_bit(KIND_SYMBOL)
                                    | kind_bit(KIND_STRING) | kind_bit(KIND_COMMENT)
                                    | kind_bit(KIND_NUMBER) | kind_bit(KIND_TAG);

endpackage

`default_nettype wire

### hdl/newick_token_validator_unit.sv
// newick token validator: per-token syntax check and node action output
// throughput: one token per cycle while rsp_stall is low, set by the combinational state update loop
// a token is registered, then decided against the tree state into the result register
// reset: synchronous, clears tree state, stream start flag and both valid flags
`default_nettype none

module newick_token_validator_unit #(
   parameter int MAX_DEPTH = ntv_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [3:0]                    req_token_kind,
   input  wire logic [ntv_pkg::REF_W-1:0]     req_token_ref,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_action,
   output logic [ntv_pkg::NODE_DEPTH_W-1:0]   rsp_node_depth,
   output logic                               rsp_node_is_leaf,
   output logic [ntv_pkg::REF_W-1:0]          rsp_value_ref,
   output logic [3:0]                         rsp_status
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [3:0]                  kind_ff;
   logic [ntv_pkg::REF_W-1:0]   ref_ff;

   // tree state
   logic [DEPTH_W-1:0]                nest_ff, nest_in;
   ntv_pkg::kind_type                 prev_ff, prev_in;
   ntv_pkg::kind_type                 lnc_ff, lnc_in;
   logic                              closed_ff, closed_in;
   logic                              node_open_ff, node_open_in;
   logic [ntv_pkg::NODE_DEPTH_W-1:0]  node_depth_ff, node_depth_in;
   logic                              node_leaf_ff, node_leaf_in;
   logic                              stream_ff, stream_in;
   logic                              tree_ff, tree_in;

   // result register
   logic                              out_valid_ff;
   ntv_pkg::action_type               act_ff, act_in;
   logic [ntv_pkg::NODE_DEPTH_W-1:0]  odepth_ff, odepth_in;
   logic                              oleaf_ff, oleaf_in;
   logic [ntv_pkg::REF_W-1:0]         oref_ff, oref_in;
   ntv_pkg::status_type               stat_ff, stat_in;

   logic                              out_free, advance, req_take;
   ntv_pkg::kind_type                 kind;
   logic [ntv_pkg::REF_W-1:0]         tref;
   logic                              fail;
   logic                              clear;
   logic [ntv_pkg::NODE_DEPTH_W-1:0]  cur_depth;
   logic                              cur_leaf;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign kind = ntv_pkg::kind_type'(kind_ff);
   assign tref = ref_ff & ntv_pkg::REF_MASK;

   always_comb begin
      nest_in       = nest_ff;
      prev_in       = prev_ff;
      lnc_in        = lnc_ff;
      closed_in     = closed_ff;
      node_open_in  = node_open_ff;
      node_depth_in = node_depth_ff;
      node_leaf_in  = node_leaf_ff;
      stream_in     = stream_ff;
      tree_in       = tree_ff;
      act_in        = ntv_pkg::ACT_NONE;
      odepth_in     = '0;
      oleaf_in      = 1'b0;
      oref_in       = '0;
      stat_in       = ntv_pkg::ST_RUNNING;
      fail          = 1'b0;
      clear         = 1'b0;
      cur_depth     = node_open_ff ? node_depth_ff : ntv_pkg::NODE_DEPTH_W'(nest_ff);
      cur_leaf      = node_open_ff ? node_leaf_ff :
                      (lnc_ff == ntv_pkg::KIND_OPEN || lnc_ff == ntv_pkg::KIND_COMMA);

      if (kind == ntv_pkg::KIND_END) begin
         stat_in   = tree_ff ? ntv_pkg::ST_NO_SEMI : ntv_pkg::ST_RUNNING;
         clear     = 1'b1;
         stream_in = 1'b0;
      end else begin
         stream_in = 1'b1;
         if (kind == ntv_pkg::KIND_NONE || kind_ff > 4'(ntv_pkg::KIND_END)) begin
            fail    = 1'b1;
            stat_in = ntv_pkg::ST_BAD_CHARS;
         end else if (kind == ntv_pkg::KIND_OPEN) begin
            if (tree_ff && !ntv_pkg::PRE_OPEN[prev_ff]) begin
               fail    = 1'b1;
               stat_in = ntv_pkg::ST_BAD_CHARS;
            end else if (closed_ff) begin
               fail    = 1'b1;
               stat_in = ntv_pkg::ST_REOPEN;
            end else if (nest_ff >= DEPTH_LIMIT) begin
               fail    = 1'b1;
               stat_in = ntv_pkg::ST_TOO_DEEP;
            end else begin
               nest_in = nest_ff + DEPTH_W'(1);
               prev_in = ntv_pkg::KIND_OPEN;
               lnc_in  = ntv_pkg::KIND_OPEN;
               tree_in = 1'b1;
            end
         end else if (!tree_ff) begin
            if (kind == ntv_pkg::KIND_COMMENT) begin
               // leading comment of a stream counts as the tree's previous token
               if (!stream_ff) begin
                  tree_in = 1'b1;
                  prev_in = ntv_pkg::KIND_COMMENT;
               end
            end else begin
               fail    = 1'b1;
               stat_in = ntv_pkg::ST_NO_START;
            end
         end else begin
            case (kind)
               ntv_pkg::KIND_SYMBOL, ntv_pkg::KIND_STRING: begin
                  if (!ntv_pkg::PRE_NAME[prev_ff]) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_BAD_CHARS;
                  end else begin
                     act_in = ntv_pkg::ACT_LABEL;
                  end
               end
               ntv_pkg::KIND_NUMBER: begin
                  if (!ntv_pkg::PRE_NUMBER[prev_ff]) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_BAD_CHARS;
                  end else begin
                     act_in = ntv_pkg::ACT_VALUE;
                  end
               end
               ntv_pkg::KIND_TAG: begin
                  act_in = ntv_pkg::ACT_TAG;
               end
               ntv_pkg::KIND_COMMENT: begin
                  act_in = ntv_pkg::ACT_COMMENT;
               end
               ntv_pkg::KIND_COMMA: begin
                  if (!ntv_pkg::PRE_COMMA[prev_ff]) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_BAD_COMMA;
                  end else begin
                     act_in = ntv_pkg::ACT_PUSH;
                  end
               end
               ntv_pkg::KIND_CLOSE: begin
                  if (nest_ff == '0) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_EXTRA_CLOSE;
                  end else if (!ntv_pkg::PRE_CLOSE[prev_ff]) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_BAD_CLOSE;
                  end else begin
                     act_in    = ntv_pkg::ACT_PUSH;
                     nest_in   = nest_ff - DEPTH_W'(1);
                     closed_in = (nest_ff == DEPTH_W'(1)) ? 1'b1 : closed_ff;
                  end
               end
               ntv_pkg::KIND_SEMI: begin
                  if (nest_ff != '0) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_MISSING_CLOSE;
                  end else if (!ntv_pkg::PRE_SEMI[prev_ff]) begin
                     fail    = 1'b1;
                     stat_in = ntv_pkg::ST_BAD_SEMI;
                  end else begin
                     act_in  = ntv_pkg::ACT_PUSH;
                     stat_in = ntv_pkg::ST_TREE_DONE;
                     clear   = 1'b1;
                  end
               end
               default: begin
                  fail    = 1'b1;
                  stat_in = ntv_pkg::ST_BAD_CHARS;
               end
            endcase

            if (!fail) begin
               odepth_in = cur_depth;
               oleaf_in  = cur_leaf;
               prev_in   = kind;
               if (kind != ntv_pkg::KIND_COMMENT) begin
                  lnc_in = kind;
               end
               if (act_in == ntv_pkg::ACT_PUSH) begin
                  node_open_in  = 1'b0;
                  node_depth_in = '0;
                  node_leaf_in  = 1'b0;
               end else begin
                  oref_in       = tref;
                  node_open_in  = 1'b1;
                  node_depth_in = cur_depth;
                  node_leaf_in  = cur_leaf;
               end
            end
         end
      end

      if (fail) begin
         act_in    = ntv_pkg::ACT_NONE;
         odepth_in = '0;
         oleaf_in  = 1'b0;
         oref_in   = '0;
         clear     = 1'b1;
      end

      if (clear) begin
         nest_in       = '0;
         prev_in       = ntv_pkg::KIND_NONE;
         lnc_in        = ntv_pkg::KIND_NONE;
         closed_in     = 1'b0;
         node_open_in  = 1'b0;
         node_depth_in = '0;
         node_leaf_in  = 1'b0;
         tree_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         nest_ff       <= '0;
         prev_ff       <= ntv_pkg::KIND_NONE;
         lnc_ff        <= ntv_pkg::KIND_NONE;
         closed_ff     <= 1'b0;
         node_open_ff  <= 1'b0;
         node_depth_ff <= '0;
         node_leaf_ff  <= 1'b0;
         stream_ff     <= 1'b0;
         tree_ff       <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff  <= 1'b1;
            nest_ff       <= nest_in;
            prev_ff       <= prev_in;
            lnc_ff        <= lnc_in;
            closed_ff     <= closed_in;
            node_open_ff  <= node_open_in;
            node_depth_ff <= node_depth_in;
            node_leaf_ff  <= node_leaf_in;
            stream_ff     <= stream_in;
            tree_ff       <= tree_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_token_kind;
         ref_ff  <= req_token_ref;
      end
      if (advance) begin
         act_ff    <= act_in;
         odepth_ff <= odepth_in;
         oleaf_ff  <= oleaf_in;
         oref_ff   <= oref_in;
         stat_ff   <= stat_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_action       = act_ff;
   assign rsp_node_depth   = odepth_ff;
   assign rsp_node_is_leaf = oleaf_ff;
   assign rsp_value_ref    = oref_ff;
   assign rsp_status       = stat_ff;

endmodule

`default_nettype wire
